### hw/rtl/leb_pkg.sv
// shared types and constants of the line edit buffer
`default_nettype none

package leb_pkg;

  localparam int LINE_STORE  = 64;
  localparam int LINE_CAP    = LINE_STORE - 2;
  localparam int CUR_W       = $clog2(LINE_STORE);
  localparam int OP_W        = 4;
  localparam int CHAR_W      = 8;
  localparam int POS_W       = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_USED_W  = 2 * CUR_W + 2 * CHAR_W + 1;

  localparam logic [CUR_W-1:0] CAP_C      = CUR_W'(LINE_CAP);
  localparam logic [CUR_W-1:0] CAP_LAST_C = CUR_W'(LINE_CAP - 1);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 4'd0,
    OP_BACKSPACE = 4'd1,
    OP_LEFT      = 4'd2,
    OP_RIGHT     = 4'd3,
    OP_HOME      = 4'd4,
    OP_END       = 4'd5,
    OP_SET_CUR   = 4'd6,
    OP_CANCEL    = 4'd7,
    OP_FINISH    = 4'd8
  } leb_op_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SETUP_INS,
    CMD_SETUP_BS,
    CMD_SHIFT_R,
    CMD_SHIFT_L,
    CMD_INS_PUT,
    CMD_BS_DONE,
    CMD_APPLY,
    CMD_FIN_START,
    CMD_FIN_NEXT,
    CMD_FIN_DONE
  } leb_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SHIFT_R,
    ST_SHIFT_L,
    ST_STAT_RD,
    ST_STAT_OUT,
    ST_FIN_RD,
    ST_FIN_OUT
  } leb_state_t;

  typedef struct packed {
    leb_cmd_t cmd;
    logic     out_line;
  } leb_ctl_t;

  typedef struct packed {
    leb_op_t op;
    logic    cursor_zero;
    logic    len_zero;
    logic    cnt_zero;
    logic    fin_last;
  } leb_stat_t;

endpackage

`default_nettype wire

### hw/rtl/leb_ctrl.sv
// controller state machine of the line edit buffer
`default_nettype none

module leb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output leb_pkg::leb_ctl_t      ctl,
  input  wire leb_pkg::leb_stat_t stat
);
  import leb_pkg::*;

  leb_state_t state_r;
  leb_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ctl.cmd      = CMD_NONE;
    ctl.out_line = 1'b0;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.cmd   = CMD_LOAD;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (stat.op)
          OP_INSERT: begin
            ctl.cmd   = CMD_SETUP_INS;
            state_nxt = ST_SHIFT_R;
          end
          OP_BACKSPACE: begin
            if (stat.cursor_zero) begin
              ctl.cmd   = CMD_APPLY;
              state_nxt = ST_STAT_RD;
            end else begin
              ctl.cmd   = CMD_SETUP_BS;
              state_nxt = ST_SHIFT_L;
            end
          end
          OP_FINISH: begin
            if (stat.len_zero) begin
              ctl.cmd   = CMD_APPLY;
              state_nxt = ST_STAT_RD;
            end else begin
              ctl.cmd   = CMD_FIN_START;
              state_nxt = ST_FIN_RD;
            end
          end
          default: begin
            ctl.cmd   = CMD_APPLY;
            state_nxt = ST_STAT_RD;
          end
        endcase
      end
      ST_SHIFT_R: begin
        if (stat.cnt_zero) begin
          ctl.cmd   = CMD_INS_PUT;
          state_nxt = ST_STAT_RD;
        end else begin
          ctl.cmd = CMD_SHIFT_R;
        end
      end
      ST_SHIFT_L: begin
        if (stat.cnt_zero) begin
          ctl.cmd   = CMD_BS_DONE;
          state_nxt = ST_STAT_RD;
        end else begin
          ctl.cmd = CMD_SHIFT_L;
        end
      end
      ST_STAT_RD: begin
        state_nxt = ST_STAT_OUT;
      end
      ST_STAT_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FIN_RD: begin
        ctl.out_line = 1'b1;
        state_nxt    = ST_FIN_OUT;
      end
      ST_FIN_OUT: begin
        ctl.out_line = 1'b1;
        out_tvalid   = 1'b1;
        if (out_tready) begin
          if (stat.fin_last) begin
            ctl.cmd   = CMD_FIN_DONE;
            state_nxt = ST_IDLE;
          end else begin
            ctl.cmd = CMD_FIN_NEXT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  a_shift_r_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT_R && stat.cnt_zero) |=> (state_r == ST_STAT_RD))
    else $error("insert shift did not finish with the status read");

  a_fin_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN_OUT && out_tready && stat.fin_last) |=> in_tready)
    else $error("line stream did not return to idle");

endmodule

`default_nettype wire

### hw/rtl/leb_dpath.sv
// datapath of the line edit buffer: character store, cursor, length and result mux
`default_nettype none

module leb_dpath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [leb_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic [leb_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic                                    out_tuser,
  output logic                                    out_tlast,
  input  wire leb_pkg::leb_ctl_t                  ctl,
  output leb_pkg::leb_stat_t                      stat
);
  import leb_pkg::*;

  logic [CHAR_W-1:0] mem [LINE_STORE];

  logic [CUR_W-1:0]        cursor_r, cursor_nxt;
  logic [CUR_W-1:0]        length_r, length_nxt;
  logic [CUR_W-1:0]        ptr_r, ptr_nxt;
  logic [CUR_W-1:0]        cnt_r, cnt_nxt;
  leb_op_t                 op_r, op_nxt;
  logic [CHAR_W-1:0]       ch_r, ch_nxt;
  logic signed [POS_W-1:0] pos_r, pos_nxt;
  logic [CHAR_W-1:0]       rdata_r;

  logic                    we;
  logic [CUR_W-1:0]        wa;
  logic [CHAR_W-1:0]       wd;
  logic [CUR_W-1:0]        cursor_inc, length_inc, length_dec;
  logic [CHAR_W-1:0]       prev_char;

  assign cursor_inc = cursor_r + 1'b1;
  assign length_inc = length_r + 1'b1;
  assign length_dec = length_r - 1'b1;

  always_comb begin
    cursor_nxt = cursor_r;
    length_nxt = length_r;
    ptr_nxt    = ptr_r;
    cnt_nxt    = cnt_r;
    op_nxt     = op_r;
    ch_nxt     = ch_r;
    pos_nxt    = pos_r;
    we         = 1'b0;
    wa         = ptr_r;
    wd         = rdata_r;
    unique case (ctl.cmd)
      CMD_NONE: begin
      end
      CMD_LOAD: begin
        op_nxt  = leb_op_t'(in_tdata[OP_W-1:0]);
        ch_nxt  = in_tdata[OP_W+CHAR_W-1:OP_W];
        pos_nxt = in_tdata[OP_W+CHAR_W+POS_W-1:OP_W+CHAR_W];
      end
      CMD_SETUP_INS: begin
        ptr_nxt = length_dec;
        cnt_nxt = length_r - cursor_r;
      end
      CMD_SETUP_BS: begin
        ptr_nxt = cursor_r;
        cnt_nxt = length_r - cursor_r;
      end
      CMD_SHIFT_R: begin
        we      = 1'b1;
        wa      = ptr_r + 1'b1;
        ptr_nxt = ptr_r - 1'b1;
        cnt_nxt = cnt_r - 1'b1;
      end
      CMD_SHIFT_L: begin
        we      = 1'b1;
        wa      = ptr_r - 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        cnt_nxt = cnt_r - 1'b1;
      end
      CMD_INS_PUT: begin
        we         = 1'b1;
        wa         = cursor_r;
        wd         = ch_r;
        cursor_nxt = (cursor_inc >= CAP_C) ? CAP_LAST_C : cursor_inc;
        length_nxt = (length_inc >= CAP_C) ? CAP_C : length_inc;
        ptr_nxt    = cursor_nxt - 1'b1;
      end
      CMD_BS_DONE: begin
        cursor_nxt = cursor_r - 1'b1;
        length_nxt = length_dec;
        ptr_nxt    = cursor_nxt - 1'b1;
      end
      CMD_APPLY: begin
        case (op_r) inside
          OP_LEFT: begin
            if (cursor_r != '0) cursor_nxt = cursor_r - 1'b1;
          end
          OP_RIGHT: begin
            if (cursor_r < length_r) cursor_nxt = cursor_inc;
          end
          OP_HOME: cursor_nxt = '0;
          OP_END:  cursor_nxt = length_r;
          OP_SET_CUR: begin
            if (pos_r[POS_W-1]) begin
              cursor_nxt = '0;
            end else if (pos_r[POS_W-2:0] > {1'b0, length_r}) begin
              cursor_nxt = length_r;
            end else begin
              cursor_nxt = pos_r[CUR_W-1:0];
            end
          end
          OP_CANCEL, OP_FINISH: begin
            cursor_nxt = '0;
            length_nxt = '0;
          end
          default: begin
          end
        endcase
        ptr_nxt = cursor_nxt - 1'b1;
      end
      CMD_FIN_START: ptr_nxt = '0;
      CMD_FIN_NEXT:  ptr_nxt = ptr_r + 1'b1;
      CMD_FIN_DONE: begin
        cursor_nxt = '0;
        length_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      length_r <= '0;
    end else begin
      cursor_r <= cursor_nxt;
      length_r <= length_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    cnt_r <= cnt_nxt;
    op_r  <= op_nxt;
    ch_r  <= ch_nxt;
    pos_r <= pos_nxt;
  end

  // store: one write port, registered read at the next pointer
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ptr_nxt];
  end

  assign stat.op          = op_r;
  assign stat.cursor_zero = (cursor_r == '0);
  assign stat.len_zero    = (length_r == '0);
  assign stat.cnt_zero    = (cnt_r == '0);
  assign stat.fin_last    = (ptr_r == length_dec);

  assign prev_char = (cursor_r != '0) ? rdata_r : '0;

  always_comb begin
    if (ctl.out_line) begin
      out_tdata = {(OUT_TDATA_W - OUT_USED_W)'(0), rdata_r, 1'b0, {CHAR_W{1'b0}},
                   {CUR_W{1'b0}}, {CUR_W{1'b0}}};
      out_tuser = 1'b1;
      out_tlast = stat.fin_last;
    end else begin
      out_tdata = {(OUT_TDATA_W - OUT_USED_W)'(0), {CHAR_W{1'b0}}, (length_r != '0),
                   prev_char, length_r, cursor_r};
      out_tuser = 1'b0;
      out_tlast = 1'b1;
    end
  end

  a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= length_r)
    else $error("cursor beyond line length");

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= CAP_C)
    else $error("line length above capacity");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cmd == CMD_FIN_DONE) |=> (length_r == '0 && cursor_r == '0))
    else $error("finished line not cleared");

endmodule

`default_nettype wire

### hw/rtl/line_edit_buffer_core.sv
// top level of the line edit buffer
//
// keystroke events enter on the in_ stream: one request carries an operation
// (insert, backspace, left, right, home, end, set cursor, cancel, finish), a
// character and a signed cursor position. every event gives one status result
// on the out_ stream (cursor, length, character before the cursor, editing flag,
// tuser low, tlast high), except finish on a non-empty line, which instead
// streams the line one character per result with tuser high and tlast on the
// final character, then clears the line.
// one event is handled at a time; in_tready is high only while the block idles.
// a request is taken in the idle state and decoded in a dispatch state; for a
// status result the store is then read and the result offered on the out_
// stream. insert and backspace away from the line start first move the
// characters behind the cursor in the store one at a time (up to 62), since the
// store has one read and one write per cycle; a finished line streams one
// character per cycle while out_tready is high. the next request is taken the
// cycle after the last result. a stalled out_tready holds the result and the block waits.
// reset clears cursor and length; the store content needs no clearing.
`default_nettype none

module line_edit_buffer_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [3:0] operation, [11:4] char_code, [19:12] new_position
  input  wire logic [leb_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [5:0] cursor, [11:6] length, [19:12] prev_char, [20] editing, [28:21] line_char
  output logic [leb_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [0] line_valid
  output logic                                out_tuser,
  output logic                                out_tlast
);
  import leb_pkg::*;

  leb_ctl_t  ctl;
  leb_stat_t stat;

  leb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl),
    .stat       (stat)
  );

  leb_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule

`default_nettype wire
